// File: rtl/line_line_distance_3d_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line distance block
// Immediate-consequence and next-cycle forms, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_DISTANCE_3D_ASSERT_SVH
`define LINE_LINE_DISTANCE_3D_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define LLD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define LLD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lld_pkg.sv
// ----------------------------------------------------------------------------
// lld_pkg
// Shared constants and types of the 3D line distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lld_pkg;

  // distance word width and its saturation value
  localparam int unsigned OUT_W = 25;
  localparam logic [OUT_W-1:0] DIST_MAX = {OUT_W{1'b1}};

  // quotient bits kept ahead of the root: root of 2*OUT_W bits fills OUT_W
  localparam int unsigned QB = 2 * OUT_W;

  // control word that travels with each word down the pipeline
  typedef struct packed {
    logic valid;
    logic parallel;
    logic degenerate;
    logic sat;
  } lld_ctl_t;

endpackage

`default_nettype wire

// File: rtl/lld_in_if.sv
// ----------------------------------------------------------------------------
// lld_in_if
// Input channel: two lines, each given by two points.
// ----------------------------------------------------------------------------
`default_nettype none

interface lld_in_if #(
  parameter int unsigned CB = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] a_orig_x;
  logic signed [CB-1:0] a_orig_y;
  logic signed [CB-1:0] a_orig_z;
  logic signed [CB-1:0] a_dest_x;
  logic signed [CB-1:0] a_dest_y;
  logic signed [CB-1:0] a_dest_z;
  logic signed [CB-1:0] b_orig_x;
  logic signed [CB-1:0] b_orig_y;
  logic signed [CB-1:0] b_orig_z;
  logic signed [CB-1:0] b_dest_x;
  logic signed [CB-1:0] b_dest_y;
  logic signed [CB-1:0] b_dest_z;

  modport source (
    output valid, a_orig_x, a_orig_y, a_orig_z, a_dest_x, a_dest_y, a_dest_z,
           b_orig_x, b_orig_y, b_orig_z, b_dest_x, b_dest_y, b_dest_z,
    input  ready
  );
  modport sink (
    input  valid, a_orig_x, a_orig_y, a_orig_z, a_dest_x, a_dest_y, a_dest_z,
           b_orig_x, b_orig_y, b_orig_z, b_dest_x, b_dest_y, b_dest_z,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/lld_out_if.sv
// ----------------------------------------------------------------------------
// lld_out_if
// Result channel: distance and the parallel / degenerate flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface lld_out_if;
  logic                      valid;
  logic                      ready;
  logic [lld_pkg::OUT_W-1:0] distance;
  logic                      parallel;
  logic                      degenerate;

  modport source (output valid, distance, parallel, degenerate, input ready);
  modport sink   (input valid, distance, parallel, degenerate, output ready);
endinterface

`default_nettype wire

// File: rtl/line_line_distance_3d.sv
// ----------------------------------------------------------------------------
// line_line_distance_3d
// Shortest distance between two infinite 3D lines, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one line pair per cycle while the skid entry is empty, and returns
// one result per pair, in order. The pipeline holds 8 vector stages, 51
// divider stages, 25 root stages and the output register; the divider
// resolves one quotient bit per stage, and the root one bit per stage.
// The distance is in units of 2^-FRAC_OUT_BITS of a coordinate step,
// floored, and saturates at all ones. Parallel lines give the distance
// from line B's first point to line A; a zero-length line A gives
// distance 0 with degenerate set. The output holds a two-entry buffer,
// so input ready depends only on registered state.
`default_nettype none

module line_line_distance_3d #(
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned FRAC_OUT_BITS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lld_in_if.sink      in_i,
  lld_out_if.source   out_o
);

  localparam int unsigned DB   = COORD_BITS + 1;
  localparam int unsigned NB   = 2 * DB + 1;
  localparam int unsigned NNW  = 2 * NB + 2;
  localparam int unsigned SQW  = 2 * (DB + NB + 2);
  localparam int unsigned NUMW = ((SQW > NNW) ? SQW : NNW) + 2 * FRAC_OUT_BITS;
  localparam int unsigned DW   = NNW;
  localparam int unsigned OW   = lld_pkg::OUT_W;

  logic                         en;
  logic signed [COORD_BITS-1:0] ao [3];
  logic signed [COORD_BITS-1:0] ad [3];
  logic signed [COORD_BITS-1:0] bo [3];
  logic signed [COORD_BITS-1:0] bd [3];
  logic [NUMW-1:0]              num;
  logic [DW-1:0]                den;
  lld_pkg::lld_ctl_t            f_ctl;
  logic [lld_pkg::QB-1:0]       quo;
  lld_pkg::lld_ctl_t            d_ctl;
  logic [OW-1:0]                root;
  lld_pkg::lld_ctl_t            s_ctl;
  logic [OW-1:0]                p_dist;

  // output register and skid entry
  logic          out_v_q, skid_v_q;
  logic [OW-1:0] out_dist_q, skid_dist_q;
  logic          out_par_q, out_deg_q, skid_par_q, skid_deg_q;
  logic          take, push;

  // whole pipeline moves unless the skid entry is occupied
  assign en         = !skid_v_q;
  assign in_i.ready = en;

  assign ao = '{in_i.a_orig_x, in_i.a_orig_y, in_i.a_orig_z};
  assign ad = '{in_i.a_dest_x, in_i.a_dest_y, in_i.a_dest_z};
  assign bo = '{in_i.b_orig_x, in_i.b_orig_y, in_i.b_orig_z};
  assign bd = '{in_i.b_dest_x, in_i.b_dest_y, in_i.b_dest_z};

  lld_front #(
    .CB   (COORD_BITS),
    .F    (FRAC_OUT_BITS),
    .NUMW (NUMW),
    .DW   (DW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .ao_i    (ao),
    .ad_i    (ad),
    .bo_i    (bo),
    .bd_i    (bd),
    .num_o   (num),
    .den_o   (den),
    .ctl_o   (f_ctl)
  );

  lld_div #(
    .NUMW (NUMW),
    .DW   (DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (num),
    .den_i  (den),
    .ctl_i  (f_ctl),
    .q_o    (quo),
    .ctl_o  (d_ctl)
  );

  lld_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .x_i    (quo),
    .ctl_i  (d_ctl),
    .root_o (root),
    .ctl_o  (s_ctl)
  );

  assign p_dist = s_ctl.sat ? lld_pkg::DIST_MAX : root;
  assign take   = out_v_q && out_o.ready;
  assign push   = s_ctl.valid && en;

  // output register fed from skid first, else from the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take || !out_v_q) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take || !out_v_q) begin
      out_dist_q <= skid_v_q ? skid_dist_q : p_dist;
      out_par_q  <= skid_v_q ? skid_par_q  : s_ctl.parallel;
      out_deg_q  <= skid_v_q ? skid_deg_q  : s_ctl.degenerate;
    end else if (push) begin
      skid_dist_q <= p_dist;
      skid_par_q  <= s_ctl.parallel;
      skid_deg_q  <= s_ctl.degenerate;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.distance   = out_dist_q;
  assign out_o.parallel   = out_par_q;
  assign out_o.degenerate = out_deg_q;

  // checks
`include "line_line_distance_3d_assert.svh"

  `LLD_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q, "skid entry held with output empty")
  `LLD_ASSERT_IMP(a_degenerate_zero, out_v_q && out_deg_q, out_par_q && (out_dist_q == '0), "degenerate word not parallel with zero distance")
  `LLD_ASSERT_NXT(a_skid_fill, !skid_v_q && out_v_q && out_o.ready, !skid_v_q, "skid filled while output was drained")

endmodule

`default_nettype wire

// File: rtl/lld_front.sv
// ----------------------------------------------------------------------------
// lld_front
// Eight-stage vector datapath: differences, cross products, dot product and
// squared norms; hands a numerator and denominator to the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_front #(
  parameter int unsigned CB   = 16,
  parameter int unsigned F    = 8,
  parameter int unsigned NUMW = 124,
  parameter int unsigned DW   = 72
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  wire logic signed [CB-1:0] ao_i [3],
  input  wire logic signed [CB-1:0] ad_i [3],
  input  wire logic signed [CB-1:0] bo_i [3],
  input  wire logic signed [CB-1:0] bd_i [3],
  output logic [NUMW-1:0]        num_o,
  output logic [DW-1:0]          den_o,
  output lld_pkg::lld_ctl_t      ctl_o
);

  localparam int unsigned DB  = CB + 1;
  localparam int unsigned PB  = 2 * DB;
  localparam int unsigned NB  = PB + 1;
  localparam int unsigned NNW = 2 * NB + 2;
  localparam int unsigned LAW = 2 * DB + 2;
  localparam int unsigned WNW = DB + NB;
  localparam int unsigned DTW = DB + NB + 2;
  localparam int unsigned HL  = (DTW + 1) / 2;
  localparam int unsigned HH  = DTW - HL;
  localparam int unsigned SQW = 2 * DTW;

  // valid bits of the first five stages
  logic [4:0] v_q;

  // stage 1: direction vectors and offset
  logic signed [DB-1:0] da_q [3];
  logic signed [DB-1:0] db_q [3];
  logic signed [DB-1:0] w1_q [3];
  // stage 2: partial products
  logic signed [PB-1:0] pn_q [6];
  logic signed [PB-1:0] pc_q [6];
  logic signed [PB-1:0] sa_q [3];
  logic signed [DB-1:0] w2_q [3];
  // stage 3: n = dA x dB, c = w x dA, |dA|^2
  logic signed [NB-1:0] n_q  [3];
  logic signed [NB-1:0] c_q  [3];
  logic signed [DB-1:0] w3_q [3];
  logic [LAW-1:0]       la3_q;
  // stage 4: products for dot and norms
  logic signed [WNW-1:0]  wn_q  [3];
  logic signed [2*NB-1:0] nsq_q [3];
  logic signed [2*NB-1:0] csq_q [3];
  logic [LAW-1:0]         la4_q;
  // stage 5: sums
  logic signed [DTW-1:0] dot5_q;
  logic [NNW-1:0]        nn5_q;
  logic [NNW-1:0]        cc5_q;
  logic [LAW-1:0]        la5_q;
  // stage 6: magnitude and flags
  lld_pkg::lld_ctl_t     c6_q;
  logic [DTW-1:0]        mag6_q;
  logic [NNW-1:0]        nn6_q;
  logic [NNW-1:0]        cc6_q;
  logic [LAW-1:0]        la6_q;
  // stage 7: halves squared
  lld_pkg::lld_ctl_t     c7_q;
  logic [2*HH-1:0]       hh7_q;
  logic [HH+HL-1:0]      hl7_q;
  logic [2*HL-1:0]       ll7_q;
  logic [NNW-1:0]        nn7_q;
  logic [NNW-1:0]        cc7_q;
  logic [LAW-1:0]        la7_q;
  // stage 8: operands of the divider
  lld_pkg::lld_ctl_t     c8_q;
  logic [NUMW-1:0]       num8_q;
  logic [DW-1:0]         den8_q;

  logic [SQW-1:0]        dot2;
  logic [NUMW-1:0]       num_d;
  logic [DW-1:0]         den_d;
  lld_pkg::lld_ctl_t     c6_d;

  // control path
  always_comb begin
    c6_d            = '0;
    c6_d.valid      = v_q[4];
    c6_d.parallel   = (nn5_q == '0);
    c6_d.degenerate = (nn5_q == '0) && (la5_q == '0);
    c6_d.sat        = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      c6_q <= '0;
      c7_q <= '0;
      c8_q <= '0;
    end else if (en_i) begin
      v_q  <= {v_q[3:0], valid_i};
      c6_q <= c6_d;
      c7_q <= c6_q;
      c8_q <= c7_q;
    end
  end

  // stages 1 to 5: vector arithmetic
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        da_q[i] <= DB'(ad_i[i]) - DB'(ao_i[i]);
        db_q[i] <= DB'(bd_i[i]) - DB'(bo_i[i]);
        w1_q[i] <= DB'(ao_i[i]) - DB'(bo_i[i]);
        sa_q[i] <= PB'(da_q[i]) * PB'(da_q[i]);
        w2_q[i] <= w1_q[i];
        w3_q[i] <= w2_q[i];
        n_q[i]  <= NB'(pn_q[2*i]) - NB'(pn_q[2*i+1]);
        c_q[i]  <= NB'(pc_q[2*i]) - NB'(pc_q[2*i+1]);
        wn_q[i]  <= WNW'(w3_q[i]) * WNW'(n_q[i]);
        nsq_q[i] <= (2*NB)'(n_q[i]) * (2*NB)'(n_q[i]);
        csq_q[i] <= (2*NB)'(c_q[i]) * (2*NB)'(c_q[i]);
      end
      // n = dA x dB
      pn_q[0] <= PB'(da_q[1]) * PB'(db_q[2]);
      pn_q[1] <= PB'(da_q[2]) * PB'(db_q[1]);
      pn_q[2] <= PB'(da_q[2]) * PB'(db_q[0]);
      pn_q[3] <= PB'(da_q[0]) * PB'(db_q[2]);
      pn_q[4] <= PB'(da_q[0]) * PB'(db_q[1]);
      pn_q[5] <= PB'(da_q[1]) * PB'(db_q[0]);
      // c = w x dA
      pc_q[0] <= PB'(w1_q[1]) * PB'(da_q[2]);
      pc_q[1] <= PB'(w1_q[2]) * PB'(da_q[1]);
      pc_q[2] <= PB'(w1_q[2]) * PB'(da_q[0]);
      pc_q[3] <= PB'(w1_q[0]) * PB'(da_q[2]);
      pc_q[4] <= PB'(w1_q[0]) * PB'(da_q[1]);
      pc_q[5] <= PB'(w1_q[1]) * PB'(da_q[0]);
      la3_q  <= LAW'(sa_q[0]) + LAW'(sa_q[1]) + LAW'(sa_q[2]);
      la4_q  <= la3_q;
      dot5_q <= DTW'(wn_q[0]) + DTW'(wn_q[1]) + DTW'(wn_q[2]);
      nn5_q  <= NNW'(nsq_q[0]) + NNW'(nsq_q[1]) + NNW'(nsq_q[2]);
      cc5_q  <= NNW'(csq_q[0]) + NNW'(csq_q[1]) + NNW'(csq_q[2]);
      la5_q  <= la4_q;
    end
  end

  // final square of |dot| from its halves, then operand select
  always_comb begin
    dot2 = (SQW'(hh7_q) << (2*HL)) + (SQW'(hl7_q) << (HL+1)) + SQW'(ll7_q);
    if (!c7_q.parallel) begin
      num_d = NUMW'(dot2) << (2*F);
      den_d = DW'(nn7_q);
    end else if (c7_q.degenerate) begin
      num_d = '0;
      den_d = DW'(1);
    end else begin
      num_d = NUMW'(cc7_q) << (2*F);
      den_d = DW'(la7_q);
    end
  end

  // stages 6 to 8
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag6_q <= dot5_q[DTW-1] ? DTW'(-dot5_q) : DTW'(dot5_q);
      nn6_q  <= nn5_q;
      cc6_q  <= cc5_q;
      la6_q  <= la5_q;
      hh7_q  <= (2*HH)'(mag6_q[DTW-1:HL]) * (2*HH)'(mag6_q[DTW-1:HL]);
      hl7_q  <= (HH+HL)'(mag6_q[DTW-1:HL]) * (HH+HL)'(mag6_q[HL-1:0]);
      ll7_q  <= (2*HL)'(mag6_q[HL-1:0]) * (2*HL)'(mag6_q[HL-1:0]);
      nn7_q  <= nn6_q;
      cc7_q  <= cc6_q;
      la7_q  <= la6_q;
      num8_q <= num_d;
      den8_q <= den_d;
    end
  end

  assign num_o = num8_q;
  assign den_o = den8_q;
  assign ctl_o = c8_q;

endmodule

`default_nettype wire

// File: rtl/lld_div.sv
// ----------------------------------------------------------------------------
// lld_div
// Pipelined restoring divider, one quotient bit a stage, with an up-front
// overflow check that marks quotients too large for the root.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_div #(
  parameter int unsigned NUMW = 124,
  parameter int unsigned DW   = 72
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire logic [NUMW-1:0]    num_i,
  input  wire logic [DW-1:0]      den_i,
  input  wire lld_pkg::lld_ctl_t  ctl_i,
  output logic [lld_pkg::QB-1:0]  q_o,
  output lld_pkg::lld_ctl_t       ctl_o
);

  localparam int unsigned QB = lld_pkg::QB;
  localparam int unsigned RW = ((NUMW > DW + QB) ? NUMW : DW + QB) + 1;

  logic [RW-1:0]     r_s [QB+1];
  logic [DW-1:0]     d_s [QB+1];
  logic [QB-1:0]     q_s [QB+1];
  lld_pkg::lld_ctl_t c_s [QB+1];
  lld_pkg::lld_ctl_t c0_d;

  // overflow: quotient would reach 2^QB
  always_comb begin
    c0_d     = ctl_i;
    c0_d.sat = (RW'(num_i) >= (RW'(den_i) << QB));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_s[0] <= '0;
    end else if (en_i) begin
      c_s[0] <= c0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_s[0] <= RW'(num_i);
      d_s[0] <= den_i;
      q_s[0] <= '0;
    end
  end

  // one trial subtraction per stage, most significant bit first
  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [RW:0] t;
    assign t = {1'b0, r_s[k-1]} - ((RW+1)'(d_s[k-1]) << (QB - k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_s[k] <= '0;
      end else if (en_i) begin
        c_s[k] <= c_s[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_s[k] <= t[RW] ? r_s[k-1] : t[RW-1:0];
        d_s[k] <= d_s[k-1];
        q_s[k] <= q_s[k-1] | (QB'(!t[RW]) << (QB - k));
      end
    end
  end

  assign q_o   = q_s[QB];
  assign ctl_o = c_s[QB];

endmodule

`default_nettype wire

// File: rtl/lld_sqrt.sv
// ----------------------------------------------------------------------------
// lld_sqrt
// Pipelined digit-by-digit integer square root, one root bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_sqrt (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire logic [lld_pkg::QB-1:0] x_i,
  input  wire lld_pkg::lld_ctl_t    ctl_i,
  output logic [lld_pkg::OUT_W-1:0] root_o,
  output lld_pkg::lld_ctl_t         ctl_o
);

  localparam int unsigned QB  = lld_pkg::QB;
  localparam int unsigned RN  = lld_pkg::OUT_W;
  localparam int unsigned RMW = RN + 2;

  logic [RMW-1:0]    rem_s  [RN+1];
  logic [RN-1:0]     root_s [RN+1];
  logic [QB-1:0]     x_s    [RN+1];
  lld_pkg::lld_ctl_t c_s    [RN+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign x_s[0]    = x_i;
  assign c_s[0]    = ctl_i;

  for (genvar k = 0; k < RN; k++) begin : g_stage
    logic [RMW+1:0] cur;
    logic [RMW+2:0] t;
    // bring down the next two radicand bits, try root*4+1
    assign cur = {rem_s[k], x_s[k][QB-1-2*k -: 2]};
    assign t   = {1'b0, cur} - (RMW+3)'({root_s[k], 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_s[k+1] <= '0;
      end else if (en_i) begin
        c_s[k+1] <= c_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= t[RMW+2] ? cur[RMW-1:0] : t[RMW-1:0];
        root_s[k+1] <= {root_s[k][RN-2:0], !t[RMW+2]};
        x_s[k+1]    <= x_s[k];
      end
    end
  end

  assign root_o = root_s[RN];
  assign ctl_o  = c_s[RN];

endmodule

`default_nettype wire

// File: tb/sv/line_line_distance_3d_tb.sv
// ----------------------------------------------------------------------------
// line_line_distance_3d_tb
// Self-checking bench for the 3D line-to-line distance pipeline: exact
// integer prediction of each distance word, directed corner pairs, random
// general, parallel and degenerate pairs, with stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_line_distance_3d_tb;

  localparam int unsigned CB = 16;
  localparam int unsigned FRAC = 8;
  localparam int LATENCY = 85;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t c[12];
  } line_pair_t;
  typedef struct {
    logic [lld_pkg::OUT_W-1:0] distance;
    logic par;
    logic deg;
  } dist_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lld_in_if #(.CB(CB)) in_ch ();
  lld_out_if out_ch ();

  line_line_distance_3d #(.COORD_BITS(CB), .FRAC_OUT_BITS(FRAC)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  dist_word_t expected_q[$];
  int mismatches = 0;
  int unexpected = 0;
  int words_sent = 0;
  int words_checked = 0;
  int n_parallel = 0;
  int n_degenerate = 0;
  int n_saturated = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;
  bit hold_out = 1'b0;

  // clock and cycle limit
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", expected_q.size());
      $display("[line_line_distance_3d] ERROR");
      $finish;
    end
  end

  // floor(sqrt(x)) for a 256-bit unsigned value
  function automatic logic [255:0] isqrt256(logic [255:0] x);
    logic [255:0] res;
    logic [255:0] cand;
    res = '0;
    for (int b = 127; b >= 0; b--) begin
      cand = res | (256'd1 << b);
      if (cand * cand <= x) res = cand;
    end
    return res;
  endfunction

  // floor(sqrt(num2/den2) * 2^FRAC), saturated to the word width
  function automatic logic [lld_pkg::OUT_W-1:0] scaled_root(logic [255:0] num2,
                                                            logic [255:0] den2);
    logic [255:0] q;
    q = isqrt256((num2 << (2 * FRAC)) / den2);
    if (q > 256'(lld_pkg::DIST_MAX)) return lld_pkg::DIST_MAX;
    return q[lld_pkg::OUT_W-1:0];
  endfunction

  function automatic logic [255:0] sq_sum(longint v0, longint v1, longint v2);
    logic signed [255:0] a, b, c;
    a = v0; b = v1; c = v2;
    return 256'(a * a + b * b + c * c);
  endfunction

  // predicted distance word for one pair of lines
  function automatic dist_word_t line_distance(line_pair_t p);
    dist_word_t r;
    longint da[3], db[3], w[3], n[3], cw[3];
    logic signed [255:0] dot;
    logic [255:0] nn, la;
    for (int i = 0; i < 3; i++) begin
      da[i] = longint'(p.c[3+i]) - longint'(p.c[i]);
      db[i] = longint'(p.c[9+i]) - longint'(p.c[6+i]);
      w[i]  = longint'(p.c[i]) - longint'(p.c[6+i]);
    end
    n[0] = da[1] * db[2] - da[2] * db[1];
    n[1] = da[2] * db[0] - da[0] * db[2];
    n[2] = da[0] * db[1] - da[1] * db[0];
    r = '{distance: '0, par: 1'b0, deg: 1'b0};
    nn = sq_sum(n[0], n[1], n[2]);
    if (nn != 0) begin
      dot = 256'(w[0]) * 256'(n[0]);
      dot = dot + 256'(w[1]) * 256'(n[1]) + 256'(w[2]) * 256'(n[2]);
      if (dot < 0) dot = -dot;
      r.distance = scaled_root(256'(dot * dot), nn);
    end else begin
      r.par = 1'b1;
      la = sq_sum(da[0], da[1], da[2]);
      if (la == 0) r.deg = 1'b1;
      else begin
        cw[0] = w[1] * da[2] - w[2] * da[1];
        cw[1] = w[2] * da[0] - w[0] * da[2];
        cw[2] = w[0] * da[1] - w[1] * da[0];
        r.distance = scaled_root(sq_sum(cw[0], cw[1], cw[2]), la);
      end
    end
    return r;
  endfunction

  // send one word, predicting its result on acceptance
  task automatic send_pair(line_pair_t p);
    dist_word_t e;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.a_orig_x, in_ch.a_orig_y, in_ch.a_orig_z} <= {p.c[0], p.c[1], p.c[2]};
    {in_ch.a_dest_x, in_ch.a_dest_y, in_ch.a_dest_z} <= {p.c[3], p.c[4], p.c[5]};
    {in_ch.b_orig_x, in_ch.b_orig_y, in_ch.b_orig_z} <= {p.c[6], p.c[7], p.c[8]};
    {in_ch.b_dest_x, in_ch.b_dest_y, in_ch.b_dest_z} <= {p.c[9], p.c[10], p.c[11]};
    do @(posedge clk_i); while (!in_ch.ready);
    e = line_distance(p);
    if (e.par) n_parallel++;
    if (e.deg) n_degenerate++;
    if (e.distance == lld_pkg::DIST_MAX) n_saturated++;
    expected_q.push_back(e);
    words_sent++;
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom_range(0, 15) - 8);
      1: return coord_t'($urandom_range(0, 511) - 256);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic line_pair_t rnd_pair();
    line_pair_t p;
    int k;
    foreach (p.c[i]) p.c[i] = rnd_coord();
    case ($urandom_range(0, 9))
      0, 1: begin
        // parallel: B direction a multiple of A's
        k = $urandom_range(0, 4) - 2;
        for (int i = 0; i < 3; i++) begin
          p.c[3+i] = p.c[i] + coord_t'($urandom_range(0, 200) - 100);
          p.c[9+i] = p.c[6+i] + coord_t'(k * (p.c[3+i] - p.c[i]));
        end
      end
      2: for (int i = 0; i < 3; i++) p.c[3+i] = p.c[i];  // A zero length
      3: for (int i = 0; i < 3; i++) p.c[9+i] = p.c[6+i];  // B zero length
      default: ;
    endcase
    return p;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_out) out_ch.ready <= 1'b0;
      else if (idle_on && $urandom_range(0, 4) == 0) out_ch.ready <= 1'b0;
      else out_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    dist_word_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected");
      end else begin
        e = expected_q.pop_front();
        words_checked++;
        if (out_ch.distance !== e.distance || out_ch.parallel !== e.par ||
            out_ch.degenerate !== e.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected dist %0d par %0b deg %0b, got %0d %0b %0b",
                     words_checked, e.distance, e.par, e.deg, out_ch.distance,
                     out_ch.parallel, out_ch.degenerate);
        end
      end
    end
  end

  function automatic line_pair_t mk(int v[12]);
    line_pair_t p;
    foreach (p.c[i]) p.c[i] = coord_t'(v[i]);
    return p;
  endfunction

  // corners: extremes, perpendicular, parallel, degenerate, saturation
  task automatic test_directed();
    int mx = 32767, mn = -32768;
    send_pair(mk('{0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1, 1}));
    send_pair(mk('{0, 0, 0, 0, 0, 0, 5, 5, 5, 7, 7, 7}));
    send_pair(mk('{0, 0, 0, 1, 0, 0, 0, 3, 0, 5, 3, 0}));
    send_pair(mk('{0, 0, 0, 1, 0, 0, 0, 4, 0, 0, 4, 0}));
    send_pair(mk('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_pair(mk('{mn, mn, mn, mx, mx, mx, mx, mn, mn, mn, mx, mx}));
    send_pair(mk('{mx, mx, mx, mn, mn, mn, mn, mx, mx, mx, mn, mn}));
    send_pair(mk('{mn, 0, 0, mn + 1, 0, 0, mx, mx, mx, mx, mx, mx}));
    send_pair(mk('{mn, mn, mn, mn + 1, mn, mn, mx, mx, mx, mx, mx + 0, mx}));
    send_pair(mk('{mn, mn, mn, mn + 1, mn, mn, mx, mx, mx, mx, mx - 1, mx}));
    send_pair(mk('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}));
    send_pair(mk('{mn, mx, mn, mx, mn, mx, mn, mx, mn, mx, mn, mx}));
    send_pair(mk('{0, 0, 0, 1, 1, 1, 0, 0, 1, 1, 1, 2}));
    send_pair(mk('{1, 2, 3, 4, 6, 8, -3, 7, 2, 9, -4, 5}));
    send_pair(mk('{mx, mx, mx, mx, mx, mx, mn, mn, mn, mx, mx, mx}));
    send_pair(mk('{21845, -21846, 10922, -10923, 1, -2, 4, -8, 16, -32, 64, -128}));
    drop_valid();
  endtask

  task automatic test_random(int count);
    repeat (count) send_pair(rnd_pair());
    drop_valid();
  endtask

  // receiver blocked for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_out = 1'b0;
      end
      test_random(200);
    join
    wait_drained();
  endtask

  task automatic test_full_rate(int count);
    idle_on = 1'b0;
    test_random(count);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.a_orig_x, in_ch.a_orig_y, in_ch.a_orig_z} = '0;
    {in_ch.a_dest_x, in_ch.a_dest_y, in_ch.a_dest_z} = '0;
    {in_ch.b_orig_x, in_ch.b_orig_y, in_ch.b_orig_z} = '0;
    {in_ch.b_dest_x, in_ch.b_dest_y, in_ch.b_dest_z} = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_drained();   // sender pauses until everything is back
    test_random(800);
    test_backpressure();
    test_full_rate(400);

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("%0d pairs checked: %0d parallel, %0d degenerate, %0d saturated",
             words_checked, n_parallel, n_degenerate, n_saturated);
    $display("stalls on both channels, a long output hold-off, full-rate tail");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[line_line_distance_3d] OK");
    end else begin
      $display("%0d mismatches, %0d unexpected", mismatches, unexpected);
      $display("[line_line_distance_3d] ERROR");
    end
    $finish;
  end

endmodule
